@@ sv/ckct_pkg.sv @@
// ----------------------------------------------------------------------------
// ckct_pkg
// shared types and constants of the coordinate key counter table
// ----------------------------------------------------------------------------
package ckct_pkg;

  localparam int unsigned MODE_W      = 3;
  localparam int unsigned COORD_W     = 8;
  localparam int unsigned KEY_W       = 16;
  localparam int unsigned CNT_W       = 16;
  localparam int unsigned ENTRIES_DEF = 128;

  localparam logic [KEY_W-1:0] FREE_KEY = 16'hFFFF;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_INCR   = 3'd2,
    MODE_QUERY  = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_CLEAR,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init_wr;
    logic load_op;
    logic scan_en;
    logic clear_wr;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic in_clear;
    logic in_scan;
    logic sweep_last;
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

@@ sv/ckct_req_if.sv @@
// ----------------------------------------------------------------------------
// ckct_req_if
// request channel: operation mode and coordinate
// ----------------------------------------------------------------------------
interface ckct_req_if;
  logic                             valid;
  logic                             ready;
  logic [ckct_pkg::MODE_W-1:0]      mode;
  logic [ckct_pkg::COORD_W-1:0]     pos_x;
  logic [ckct_pkg::COORD_W-1:0]     pos_y;

  modport source (output valid, mode, pos_x, pos_y, input ready);
  modport sink   (input valid, mode, pos_x, pos_y, output ready);
endinterface

@@ sv/ckct_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ckct_rsp_if
// response channel: success flag and counter value
// ----------------------------------------------------------------------------
interface ckct_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ckct_pkg::CNT_W-1:0]   count_out;

  modport source (output valid, ok, count_out, input ready);
  modport sink   (input valid, ok, count_out, output ready);
endinterface

@@ sv/ckct_ram.sv @@
// ----------------------------------------------------------------------------
// ckct_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module ckct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/ckct_ctrl.sv @@
// ----------------------------------------------------------------------------
// ckct_ctrl
// controller: init sweep, scan, clear sweep and commit sequencing
// ----------------------------------------------------------------------------
module ckct_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  ckct_pkg::stat_t stat_i,
  output ckct_pkg::cmd_t  cmd_o
);

  ckct_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ckct_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ckct_pkg::ST_INIT: begin
        cmd_o.init_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ckct_pkg::ST_IDLE;
        end
      end
      ckct_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_op = 1'b1;
          if (stat_i.in_clear) begin
            state_d = ckct_pkg::ST_CLEAR;
          end else if (stat_i.in_scan) begin
            state_d = ckct_pkg::ST_SCAN;
          end else begin
            state_d = ckct_pkg::ST_DONE;
          end
        end
      end
      ckct_pkg::ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ckct_pkg::ST_DONE;
        end
      end
      ckct_pkg::ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = ckct_pkg::ST_DONE;
        end
      end
      ckct_pkg::ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ckct_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ckct_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ sv/ckct_dp.sv @@
// ----------------------------------------------------------------------------
// ckct_dp
// datapath: key and counter memories, scan pointer, hit capture, result reg
// ----------------------------------------------------------------------------
module ckct_dp #(
  parameter int unsigned ENTRIES = ckct_pkg::ENTRIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [ckct_pkg::MODE_W-1:0]    mode_i,
  input  logic [ckct_pkg::COORD_W-1:0]   pos_x_i,
  input  logic [ckct_pkg::COORD_W-1:0]   pos_y_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic                           ok_o,
  output logic [ckct_pkg::CNT_W-1:0]     count_out_o,
  input  ckct_pkg::cmd_t                 cmd_i,
  output ckct_pkg::stat_t                stat_o
);

  localparam int unsigned AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST   = AW'(ENTRIES - 1);

  logic [ckct_pkg::MODE_W-1:0] mode_q;
  logic [ckct_pkg::KEY_W-1:0]  key_q;
  logic [AW-1:0]               addr_q, idx_q, hit_idx_q;
  logic                        issued_all_q, rd_vld_q, found_q;
  logic [ckct_pkg::CNT_W-1:0]  hit_cnt_q;
  logic                        out_valid_q, ok_q;
  logic [ckct_pkg::CNT_W-1:0]  count_q;

  logic [ckct_pkg::KEY_W-1:0]  key_rdata, key_wdata, target;
  logic [ckct_pkg::CNT_W-1:0]  cnt_rdata, cnt_wdata;
  logic [AW-1:0]               key_waddr;
  logic                        key_we, cnt_we, rd_issue, match, capture;
  logic                        is_ins, is_rem, is_inc, is_qry, is_clr;
  logic                        res_ok;
  logic [ckct_pkg::CNT_W-1:0]  res_cnt;

  assign is_ins = (mode_q == ckct_pkg::MODE_INSERT);
  assign is_rem = (mode_q == ckct_pkg::MODE_REMOVE);
  assign is_inc = (mode_q == ckct_pkg::MODE_INCR);
  assign is_qry = (mode_q == ckct_pkg::MODE_QUERY);
  assign is_clr = (mode_q == ckct_pkg::MODE_CLEAR);

  assign target   = is_ins ? ckct_pkg::FREE_KEY : key_q;
  assign match    = (key_rdata == target);
  assign rd_issue = cmd_i.scan_en && !issued_all_q;
  assign capture  = cmd_i.scan_en && rd_vld_q && (match || (idx_q == LAST));

  // memory write selection
  always_comb begin
    key_we    = cmd_i.init_wr || cmd_i.clear_wr ||
                (cmd_i.commit && found_q && (is_ins || is_rem));
    key_waddr = (cmd_i.init_wr || cmd_i.clear_wr) ? addr_q : hit_idx_q;
    key_wdata = (cmd_i.commit && is_ins) ? key_q : ckct_pkg::FREE_KEY;
    cnt_we    = cmd_i.init_wr || (cmd_i.commit && found_q && (is_ins || is_inc));
    cnt_wdata = (cmd_i.commit && is_inc) ? hit_cnt_q + 1'b1 : '0;
  end

  ckct_ram #(
    .WIDTH (ckct_pkg::KEY_W),
    .DEPTH (ENTRIES)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .raddr_i (addr_q),
    .rdata_o (key_rdata)
  );

  ckct_ram #(
    .WIDTH (ckct_pkg::CNT_W),
    .DEPTH (ENTRIES)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (key_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (addr_q),
    .rdata_o (cnt_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q       <= '0;
      issued_all_q <= 1'b0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      rd_vld_q <= rd_issue;
      if (cmd_i.load_op) begin
        addr_q       <= '0;
        issued_all_q <= 1'b0;
        found_q      <= 1'b0;
      end else if (cmd_i.init_wr || cmd_i.clear_wr || rd_issue) begin
        addr_q <= addr_q + 1'b1;
        if (addr_q == LAST) begin
          issued_all_q <= 1'b1;
        end
      end
      if (capture) begin
        found_q <= match;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result of the operation
  always_comb begin
    res_ok  = 1'b0;
    res_cnt = '0;
    if (is_clr) begin
      res_ok = 1'b1;
    end else if (is_ins || is_rem || is_inc || is_qry) begin
      res_ok = found_q;
      if (is_qry && found_q) begin
        res_cnt = hit_cnt_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q <= addr_q;
    if (cmd_i.load_op) begin
      mode_q <= mode_i;
      key_q  <= {pos_x_i, pos_y_i};
    end
    if (capture) begin
      hit_idx_q <= idx_q;
      hit_cnt_q <= cnt_rdata;
    end
    if (cmd_i.commit) begin
      ok_q    <= res_ok;
      count_q <= res_cnt;
    end
  end

  always_comb begin
    stat_o.in_clear   = (mode_i == ckct_pkg::MODE_CLEAR);
    stat_o.in_scan    = (mode_i inside {ckct_pkg::MODE_INSERT, ckct_pkg::MODE_REMOVE,
                                        ckct_pkg::MODE_INCR, ckct_pkg::MODE_QUERY});
    stat_o.sweep_last = (addr_q == LAST);
    stat_o.scan_done  = capture;
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = ok_q;
  assign count_out_o = count_q;

endmodule

@@ sv/coordinate_key_counter_table_top.sv @@
// ----------------------------------------------------------------------------
// coordinate_key_counter_table_top
// table of coordinate keys with 16-bit counters, first-match operations
// ----------------------------------------------------------------------------
// req_i carries one transaction per operation: mode (insert, remove,
// increment, query, clear all) and the coordinate pos_x/pos_y, forming the
// key pos_x*256+pos_y. rsp_o returns one transaction per request with ok and
// count_out (the counter for a successful query, else 0).
// one request is handled at a time; ready on req_i is high only while idle.
// a scan reads key and counter memories one slot per cycle through their
// registered read port, stopping at the first qualifying slot. clear all
// sweeps every slot. after reset a clearing pass writes every key free and
// every counter zero; req_i is not ready during it.
// the response sits in an output register; if rsp_o is stalled, the next
// request is still accepted and worked on, and the block waits only before
// committing its own result until the register is taken.
// ----------------------------------------------------------------------------
module coordinate_key_counter_table_top #(
  parameter int unsigned ENTRIES = ckct_pkg::ENTRIES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ckct_req_if.sink    req_i,
  ckct_rsp_if.source  rsp_o
);

  ckct_pkg::cmd_t  cmd;
  ckct_pkg::stat_t stat;

  ckct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ckct_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mode_i      (req_i.mode),
    .pos_x_i     (req_i.pos_x),
    .pos_y_i     (req_i.pos_y),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .ok_o        (rsp_o.ok),
    .count_out_o (rsp_o.count_out),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
